### hw/rtl/aikd_pkg.sv
// Shared constants and types for the per-key asymmetric integrator debounce block.
// Depends on nothing; every other file of the block imports it.
package aikd_pkg;

  localparam int NUM_KEYS   = 10;
  localparam int FIELD_BITS = 10;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Only keys that have a bit in the sample word get an integrator.
  localparam int LANES = (NUM_KEYS < FIELD_BITS) ? NUM_KEYS : FIELD_BITS;

  localparam logic [THR_W-1:0]      PRESS_THR_RST   = THR_W'(1);
  localparam logic [THR_W-1:0]      RELEASE_THR_RST = THR_W'(5);
  localparam logic [FIELD_BITS-1:0] KEY_MASK_RST    = FIELD_BITS'(10'h3FF);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_THR   = 2'd0,
    CFG_RELEASE_THR = 2'd1,
    CFG_KEY_PRESENT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] press_thr;
    logic [THR_W-1:0] release_thr;
  } thr_cfg_t;

endpackage

### hw/rtl/aikd_if.sv
// Handshake interfaces for the debounce block: raw sample, debounced result and config write.
// Depends on aikd_pkg.
interface aikd_raw_if import aikd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] raw_keys;

  modport source (output valid, output raw_keys, input ready);
  modport sink   (input valid, input raw_keys, output ready);
endinterface

interface aikd_deb_if import aikd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] debounced_keys;

  modport source (output valid, output debounced_keys, input ready);
  modport sink   (input valid, input debounced_keys, output ready);
endinterface

interface aikd_cfg_if import aikd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/aikd_lane.sv
// One key integrator: debounced state and saturating mismatch counter.
// Depends on aikd_pkg.
module aikd_lane import aikd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  logic     present,
  input  logic     raw_bit,
  input  thr_cfg_t thr_cfg,
  output logic     pressed_nxt
);

  logic             pressed_r;
  logic [THR_W-1:0] cnt_r;
  logic [THR_W-1:0] cnt_nxt;
  logic             sample_down;
  logic [THR_W-1:0] thr;
  logic [THR_W:0]   cnt_inc;

  assign sample_down = ~raw_bit;
  assign thr         = pressed_r ? thr_cfg.release_thr : thr_cfg.press_thr;
  assign cnt_inc     = {1'b0, cnt_r} + (THR_W+1)'(1);

  always_comb begin
    pressed_nxt = pressed_r;
    cnt_nxt     = cnt_r;
    if (advance && present) begin
      if (sample_down == pressed_r) begin
        cnt_nxt = (cnt_r > THR_W'(1)) ? cnt_r - THR_W'(1) : '0;
      end else if (cnt_inc >= {1'b0, thr}) begin
        // Covers a zero threshold and a counter left above a lowered threshold.
        pressed_nxt = sample_down;
        cnt_nxt     = '0;
      end else begin
        cnt_nxt = cnt_inc[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      pressed_r <= pressed_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/aikd_merge.sv
// Packs the lane states into the active-low mask and holds it in an output register
// backed by a skid register. Depends on aikd_pkg.
module aikd_merge import aikd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [LANES-1:0]      lane_pressed,
  input  logic [FIELD_BITS-1:0] present_mask,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FIELD_BITS-1:0] out_keys
);

  logic [FIELD_BITS-1:0] word;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  logic [FIELD_BITS-1:0] out_data_r;
  logic [FIELD_BITS-1:0] skid_data_r;
  logic                  out_free;

  for (genvar i = 0; i < FIELD_BITS; i++) begin : g_bit
    if (i < LANES) begin : g_key
      assign word[i] = present_mask[i] ? ~lane_pressed[i] : 1'b1;
    end else begin : g_none
      assign word[i] = 1'b1;
    end
  end

  assign out_free  = ~out_valid_r | out_ready;
  assign in_ready  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_keys  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      // The skid register is empty whenever a word is pushed.
      if (out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= word;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= word;
      end
    end else if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/asymmetric_integrator_key_debounce_top.sv
// A result word is registered into the output register when its sample word is accepted and
// the output register is free; a result held back by the sink waits in the skid register.
// Throughput: one sample word per cycle while the skid register is empty; every key has its own integrator lane.
// A two-entry output stage (register plus skid) keeps input ready while one word waits.
// Reset: press threshold 1, release threshold 5, all keys present, released, counters zero.
// Top level of the per-key debounce block. Depends on aikd_pkg, aikd_if, aikd_lane, aikd_merge.
module asymmetric_integrator_key_debounce_top import aikd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  aikd_raw_if.sink   in_if,
  aikd_deb_if.source out_if,
  aikd_cfg_if.sink   cfg_if
);

  thr_cfg_t              thr_cfg_r;
  logic [FIELD_BITS-1:0] key_mask_r;
  logic                  push;
  logic                  in_ready;
  logic [LANES-1:0]      lane_pressed;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_cfg_r.press_thr   <= PRESS_THR_RST;
      thr_cfg_r.release_thr <= RELEASE_THR_RST;
      key_mask_r            <= KEY_MASK_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_PRESS_THR:   thr_cfg_r.press_thr   <= cfg_if.data[THR_W-1:0];
        CFG_RELEASE_THR: thr_cfg_r.release_thr <= cfg_if.data[THR_W-1:0];
        CFG_KEY_PRESENT: key_mask_r            <= cfg_if.data[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = in_ready;
  assign push        = in_if.valid & in_ready;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    aikd_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .advance     (push),
      .present     (key_mask_r[i]),
      .raw_bit     (in_if.raw_keys[i]),
      .thr_cfg     (thr_cfg_r),
      .pressed_nxt (lane_pressed[i])
    );
  end

  aikd_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .lane_pressed (lane_pressed),
    .present_mask (key_mask_r),
    .in_ready     (in_ready),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_keys     (out_if.debounced_keys)
  );

endmodule

### hw/rtl/aikd_checker.sv
// Port-level checks for the debounce top level, attached to it by the bind below.
// Depends on aikd_pkg and asymmetric_integrator_key_debounce_top.
module aikd_checker import aikd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FIELD_BITS-1:0] out_keys
);

  // The output stage comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input is held off only while both output entries are occupied.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output stage");

  // After an accepted sample the output stage always holds a valid result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample produced no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_keys))
    else $error("stalled result word changed");

endmodule

bind asymmetric_integrator_key_debounce_top aikd_checker u_aikd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_keys  (out_if.debounced_keys)
);

### test/tb_asymmetric_integrator_key_debounce_top.sv
// Self-checking testbench for the per-key asymmetric integrator debounce block.
// Uses aikd_pkg, the aikd_if channel interfaces and asymmetric_integrator_key_debounce_top.
// A directed stimulus list runs first, then random bounce patterns under changing settings.
module tb_asymmetric_integrator_key_debounce_top;
  import aikd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT     = 2000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int MAX_SHOWN       = 10;

  // Index 3 has no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [FIELD_BITS-1:0] raw;
    bit                    pinned;
    logic [FIELD_BITS-1:0] word;
  } row_t;

  logic clk;
  logic rst_n;

  aikd_raw_if in_if();
  aikd_deb_if out_if();
  aikd_cfg_if cfg_if();

  asymmetric_integrator_key_debounce_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Debounce state kept by the testbench.
  logic [THR_W-1:0]      press_thr;
  logic [THR_W-1:0]      release_thr;
  logic [FIELD_BITS-1:0] present_mask;
  logic                  key_down [LANES];
  logic [THR_W-1:0]      key_cnt  [LANES];

  logic [FIELD_BITS-1:0] debounced_q[$];

  // Typed-in expectation that travels with the sample word it belongs to.
  logic                  pin_on;
  logic [FIELD_BITS-1:0] pin_word;

  bit idle_on;
  int stall_left;
  int quiet_cycles;
  int fault_cnt;
  int sample_cnt;
  int result_cnt;
  int cfg_cnt;
  int flip_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_debounce_state();
    press_thr    = PRESS_THR_RST;
    release_thr  = RELEASE_THR_RST;
    present_mask = KEY_MASK_RST;
    for (int k = 0; k < LANES; k++) begin
      key_down[k] = 1'b0;
      key_cnt[k]  = '0;
    end
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_PRESS_THR:   press_thr    = data[THR_W-1:0];
      CFG_RELEASE_THR: release_thr  = data[THR_W-1:0];
      CFG_KEY_PRESENT: present_mask = data[FIELD_BITS-1:0];
      default: ;
    endcase
  endfunction

  // One scan tick: advance every present key's integrator, return the active-low mask.
  function automatic logic [FIELD_BITS-1:0] debounce_tick(input logic [FIELD_BITS-1:0] raw);
    logic [FIELD_BITS-1:0] mask;
    logic                  hit;
    logic [THR_W-1:0]      thr;
    mask = '1;
    for (int k = 0; k < LANES; k++) begin
      if (present_mask[k]) begin
        hit = !raw[k];
        if (hit == key_down[k]) begin
          if (key_cnt[k] != '0) key_cnt[k] = key_cnt[k] - 1'b1;
        end else begin
          thr = key_down[k] ? release_thr : press_thr;
          // Covers a zero threshold and a counter left above a lowered threshold.
          if (int'(key_cnt[k]) + 1 >= int'(thr)) begin
            key_down[k] = hit;
            key_cnt[k]  = '0;
            flip_cnt++;
          end else begin
            key_cnt[k] = key_cnt[k] + 1'b1;
          end
        end
        if (key_down[k]) mask[k] = 1'b0;
      end
    end
    return mask;
  endfunction

  always @(posedge clk) begin
    logic [FIELD_BITS-1:0] want;
    if (!rst_n) begin
      reset_debounce_state();
      debounced_q.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        apply_reg_write(cfg_if.index, cfg_if.data);
        cfg_cnt++;
      end
      if (in_if.valid && in_if.ready) begin
        want = debounce_tick(in_if.raw_keys);
        debounced_q.push_back(pin_on ? pin_word : want);
        sample_cnt++;
      end
      if (out_if.valid && out_if.ready) begin
        result_cnt++;
        if (debounced_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= MAX_SHOWN)
            $display("[%0t] result word %h arrived with nothing expected",
                     $time, out_if.debounced_keys);
        end else begin
          want = debounced_q.pop_front();
          if (out_if.debounced_keys !== want) begin
            fault_cnt++;
            if (fault_cnt <= MAX_SHOWN)
              $display("[%0t] debounced_keys mismatch: expected %h, got %h",
                       $time, want, out_if.debounced_keys);
          end
        end
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(1, 9) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic row_t smp(input logic [FIELD_BITS-1:0] raw, input bit pinned = 1'b0,
                               input logic [FIELD_BITS-1:0] word = '0);
    row_t r;
    r.kind   = ROW_SAMPLE;
    r.idx    = '0;
    r.data   = '0;
    r.raw    = raw;
    r.pinned = pinned;
    r.word   = word;
    return r;
  endfunction

  function automatic row_t wr(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.kind   = ROW_CFG;
    r.idx    = idx;
    r.data   = data;
    r.raw    = '0;
    r.pinned = 1'b0;
    r.word   = '0;
    return r;
  endfunction

  function automatic logic [THR_W-1:0] pick_thr();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return THR_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_present();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r <= 2) return FIELD_BITS'($urandom);
    return KEY_MASK_RST;
  endfunction

  // Sample words keep valid high after acceptance; the caller lowers it.
  task automatic send_sample(input logic [FIELD_BITS-1:0] raw, input bit pinned,
                             input logic [FIELD_BITS-1:0] word);
    in_if.valid    <= 1'b1;
    in_if.raw_keys <= raw;
    pin_on         <= pinned;
    pin_word       <= word;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (debounced_q.size() != 0);
  endtask

  task automatic idle_gap();
    in_if.valid <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  initial begin
    row_t                  plan[$];
    logic [FIELD_BITS-1:0] level;
    logic [FIELD_BITS-1:0] raw;
    int                    r;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.raw_keys = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    pin_on         = 1'b0;
    pin_word       = '0;
    idle_on        = 1'b1;
    stall_left     = 0;
    quiet_cycles   = 0;
    fault_cnt      = 0;
    sample_cnt     = 0;
    result_cnt     = 0;
    cfg_cnt        = 0;
    flip_cnt       = 0;
    reset_debounce_state();

    // Reset thresholds: one tick presses, five ticks release.
    plan.push_back(smp(10'h3FF, 1'b1, 10'h3FF));
    plan.push_back(smp(10'h000, 1'b1, 10'h000));
    repeat (5) plan.push_back(smp(10'h3FF));
    // Zero thresholds make the mask follow the raw word.
    plan.push_back(wr(CFG_PRESS_THR, 10'h000));
    plan.push_back(wr(CFG_RELEASE_THR, 10'h000));
    plan.push_back(smp(10'h155, 1'b1, 10'h155));
    plan.push_back(smp(10'h2AA, 1'b1, 10'h2AA));
    // With every key absent the mask reads all released.
    plan.push_back(wr(CFG_KEY_PRESENT, 10'h000));
    plan.push_back(smp(10'h000, 1'b1, 10'h3FF));
    plan.push_back(wr(CFG_KEY_PRESENT, 10'h3FF));
    // Upper data bits must be dropped from threshold writes.
    plan.push_back(wr(CFG_PRESS_THR, 10'h3FF));
    plan.push_back(wr(CFG_RELEASE_THR, 10'h30A));
    repeat (3) plan.push_back(smp(10'h155));
    // Counters now sit above the new thresholds and the next sample must flip them.
    plan.push_back(wr(CFG_PRESS_THR, 10'h001));
    plan.push_back(wr(CFG_RELEASE_THR, 10'h002));
    plan.push_back(smp(10'h155));
    plan.push_back(wr(CFG_UNUSED_IDX, 10'h000));
    plan.push_back(wr(CFG_KEY_PRESENT, 10'h0F0));
    plan.push_back(smp(10'h000));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind == ROW_SAMPLE) begin
          in_if.valid <= 1'b0;
          wait_drained();
        end
        write_reg(plan[i].idx, plan[i].data);
        if (i == plan.size() - 1 || plan[i+1].kind == ROW_SAMPLE) cfg_if.valid <= 1'b0;
      end else begin
        send_sample(plan[i].raw, plan[i].pinned, plan[i].word);
        if ($urandom_range(0, 4) == 0) idle_gap();
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_if.valid <= 1'b0;
      wait_drained();
      idle_on = (ph == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_reg(CFG_PRESS_THR, {2'($urandom_range(0, 3)), pick_thr()});
      write_reg(CFG_RELEASE_THR, {2'($urandom_range(0, 3)), pick_thr()});
      write_reg(CFG_KEY_PRESENT, pick_present());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
      cfg_if.valid <= 1'b0;
      level = FIELD_BITS'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off once, in the middle of the second phase, until the pipeline has emptied.
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) begin
          in_if.valid <= 1'b0;
          wait_drained();
        end
        // Mostly held levels so integrators reach threshold, with bounces and noise.
        r = $urandom_range(0, 15);
        if (r <= 1) level = FIELD_BITS'($urandom);
        if (r == 2) raw = FIELD_BITS'($urandom);
        else if (r == 3) raw = level ^ (FIELD_BITS'(1) << $urandom_range(0, FIELD_BITS - 1));
        else raw = level;
        send_sample(raw, 1'b0, '0);
        if (idle_on && $urandom_range(0, 5) == 0) idle_gap();
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    fault_cnt += debounced_q.size();

    $display("Covered %0d sample words and %0d result words over %0d register writes,",
             sample_cnt, result_cnt, cfg_cnt);
    $display("with %0d key state changes under zero, small and full-scale thresholds.",
             flip_cnt);
    if (fault_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
